### rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int CHAR_W   = 8;
	localparam int COLUMN_W = 7;
	localparam int ROW_W    = 5;
	localparam int COLOR_W  = 4;
	localparam int WORD_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_SETPOS = 1'b1;

	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CODE_BLANK     = 8'd32;

	localparam int TAB_STEP = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd1;

	localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd1;
	localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;

	typedef struct packed {
		logic                kind;
		logic [CHAR_W-1:0]   char_code;
		logic [COLUMN_W-1:0] column;
		logic [ROW_W-1:0]    row;
	} item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] background;
		logic [COLOR_W-1:0] foreground;
	} colors_t;

endpackage

### rtl/core/tcw_if.sv
`timescale 1ns / 1ps

interface tcw_item_if import tcw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [CHAR_W-1:0]   char_code;
	logic [COLUMN_W-1:0] column;
	logic [ROW_W-1:0]    row;

	modport source (output valid, output kind, output char_code, output column, output row,
		input ready);
	modport sink (input valid, input kind, input char_code, input column, input row,
		output ready);
endinterface

interface tcw_cell_if import tcw_pkg::*; #(
	parameter int ADDR_W = 11
) ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] cell_address;
	logic [WORD_W-1:0] cell_word;

	modport source (output valid, output cell_address, output cell_word, input ready);
	modport sink (input valid, input cell_address, input cell_word, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COLOR_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor import tcw_pkg::*; #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25,
	parameter int ADDR_W         = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  item_t             item,
	input  colors_t           colors,
	output logic              res_valid,
	output logic [ADDR_W-1:0] res_address,
	output logic [WORD_W-1:0] res_word
);

	localparam int CW   = $clog2(SCREEN_COLUMNS);
	localparam int RW   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int QMAX = ((1 << COLUMN_W) - 1) / SCREEN_COLUMNS;
	localparam int QW   = 4;
	localparam int RTW  = ROW_W + 1;

	localparam logic [CW:0]     COLS_X   = (CW+1)'(SCREEN_COLUMNS);
	localparam logic [CW-1:0]   LAST_COL = CW'(SCREEN_COLUMNS - 1);
	localparam logic [RW-1:0]   LAST_ROW = RW'(SCREEN_ROWS - 1);
	localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] TAB_A  = ADDR_W'(TAB_STEP);

	logic [CW-1:0]     col_q, col_n;
	logic [RW-1:0]     row_q, row_n;
	logic [ADDR_W-1:0] lin_q, lin_n;

	logic [QW-1:0]     qc;
	logic [CW-1:0]     col_rem;
	logic [RTW-1:0]    row_tot;
	logic [CW:0]       col_t;
	logic [CHAR_W-1:0] res_char;

	always_comb begin
		qc = '0;
		for (int k = 1; k <= QMAX; k++) begin
			if (int'(item.column) >= k * SCREEN_COLUMNS) begin
				qc = qc + QW'(1);
			end
		end
		col_rem = CW'(int'(item.column) - int'(qc) * SCREEN_COLUMNS);
		row_tot = RTW'(item.row) + RTW'(qc);
	end

	always_comb begin
		col_n     = col_q;
		row_n     = row_q;
		lin_n     = lin_q;
		res_valid = 1'b0;
		res_char  = item.char_code;
		res_address = lin_q;
		col_t     = '0;
		if (item.kind == KIND_SETPOS) begin
			if (int'(row_tot) >= SCREEN_ROWS) begin
				col_n = '0;
				row_n = '0;
				lin_n = '0;
			end else begin
				col_n = col_rem;
				row_n = RW'(row_tot);
				lin_n = ADDR_W'(int'(row_tot) * SCREEN_COLUMNS + int'(col_rem));
			end
		end else begin
			case (item.char_code)
				CODE_NEWLINE: begin
					if (row_q == LAST_ROW) begin
						col_n = '0;
						row_n = '0;
						lin_n = '0;
					end else begin
						col_n = '0;
						row_n = row_q + RW'(1);
						lin_n = lin_q - ADDR_W'(col_q) + COLS_A;
					end
				end
				CODE_TAB: begin
					col_t = {1'b0, col_q} + (CW+1)'(TAB_STEP);
					if (col_t >= COLS_X) begin
						if (row_q == LAST_ROW) begin
							col_n = '0;
							row_n = '0;
							lin_n = '0;
						end else begin
							col_n = CW'(col_t - COLS_X);
							row_n = row_q + RW'(1);
							lin_n = lin_q + TAB_A;
						end
					end else begin
						col_n = CW'(col_t);
						lin_n = lin_q + TAB_A;
					end
				end
				CODE_BACKSPACE: begin
					res_valid = 1'b1;
					res_char  = CODE_BLANK;
					if (lin_q != '0) begin
						lin_n = lin_q - ADDR_W'(1);
						if (col_q == '0) begin
							col_n = LAST_COL;
							row_n = row_q - RW'(1);
						end else begin
							col_n = col_q - CW'(1);
						end
					end
					res_address = lin_n;
				end
				default: begin
					res_valid = 1'b1;
					if (col_q == LAST_COL) begin
						if (row_q == LAST_ROW) begin
							col_n = '0;
							row_n = '0;
							lin_n = '0;
						end else begin
							col_n = '0;
							row_n = row_q + RW'(1);
							lin_n = lin_q + ADDR_W'(1);
						end
					end else begin
						col_n = col_q + CW'(1);
						lin_n = lin_q + ADDR_W'(1);
					end
				end
			endcase
		end
	end

	assign res_word = {colors.background, colors.foreground, res_char};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lin_q <= '0;
		end else if (step) begin
			col_q <= col_n;
			row_q <= row_n;
			lin_q <= lin_n;
		end
	end

endmodule

### rtl/core/tcw_out_reg.sv
`timescale 1ns / 1ps

module tcw_out_reg import tcw_pkg::*; #(
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [ADDR_W-1:0] address,
	input  logic [WORD_W-1:0] word,
	output logic              space,
	tcw_cell_if.source        screen
);

	logic              valid_q;
	logic [ADDR_W-1:0] address_q;
	logic [WORD_W-1:0] word_q;

	assign space = !valid_q || screen.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			address_q <= address;
			word_q    <= word;
		end
	end

	assign screen.valid        = valid_q;
	assign screen.cell_address = address_q;
	assign screen.cell_word    = word_q;

endmodule

### rtl/core/text_console_char_writer.sv
`timescale 1ns / 1ps
// Channel  Role    Payload
// item     sink    kind, char_code, column, row
// screen   source  cell_address, cell_word
// cfg      sink    index, data (0 background, 1 foreground)
//
// One request is taken per cycle while the cell output does not stall. Each
// request is registered, then the cursor update runs and writes the output
// register. The cursor row, column and linear index are updated together.
// Reset clears the cursor and sets the colors to 1 and 15. A stalled cell
// output holds a pending request that writes a cell.

module text_console_char_writer import tcw_pkg::*; #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	tcw_item_if.sink   item,
	tcw_cell_if.source screen,
	tcw_cfg_if.sink    cfg
);

	localparam int ADDR_W = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);

	item_t             item_s1;
	logic              valid_s1;
	colors_t           colors_q;
	logic              advance;
	logic              space;
	logic              res_valid;
	logic [ADDR_W-1:0] res_address;
	logic [WORD_W-1:0] res_word;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.background <= BACKGROUND_RESET;
			colors_q.foreground <= FOREGROUND_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BACKGROUND: colors_q.background <= cfg.data;
				CFG_FOREGROUND: colors_q.foreground <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign advance    = valid_s1 && (!res_valid || space);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind      <= item.kind;
			item_s1.char_code <= item.char_code;
			item_s1.column    <= item.column;
			item_s1.row       <= item.row;
		end
	end

	tcw_cursor #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS),
		.ADDR_W         (ADDR_W)
	) u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.colors      (colors_q),
		.res_valid   (res_valid),
		.res_address (res_address),
		.res_word    (res_word)
	);

	tcw_out_reg #(
		.ADDR_W (ADDR_W)
	) u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res_valid),
		.address (res_address),
		.word    (res_word),
		.space   (space),
		.screen  (screen)
	);

endmodule

### dv/tcw_cell_checker.sv
`timescale 1ns / 1ps

module tcw_cell_checker import tcw_pkg::*; #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25,
	parameter int ADDR_W         = 11
) (
	input  logic clk,
	input  logic arst_n,
	tcw_item_if  item_mon,
	tcw_cell_if  cell_mon,
	tcw_cfg_if   cfg_mon,
	output int   mismatches,
	output int   cells_pending
);

	localparam int SCREEN_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] word;
	} cell_t;

	cell_t              expected_cells[$];
	int                 cursor;
	logic [COLOR_W-1:0] background;
	logic [COLOR_W-1:0] foreground;

	function automatic int wrap_to_screen(input int pos);
		return (pos >= SCREEN_CELLS) ? 0 : pos;
	endfunction

	task automatic predict_cell_write(input item_t req);
		cell_t             entry;
		logic [CHAR_W-1:0] glyph;
		if (req.kind == KIND_SETPOS) begin
			cursor = wrap_to_screen(int'(req.row) * SCREEN_COLUMNS + int'(req.column));
		end else if (req.char_code == CODE_NEWLINE) begin
			cursor = wrap_to_screen((cursor / SCREEN_COLUMNS + 1) * SCREEN_COLUMNS);
		end else if (req.char_code == CODE_TAB) begin
			cursor = wrap_to_screen(cursor + TAB_STEP);
		end else begin
			if (req.char_code == CODE_BACKSPACE) begin
				if (cursor > 0)
					cursor = cursor - 1;
				glyph = CODE_BLANK;
			end else begin
				glyph = req.char_code;
			end
			entry.address = ADDR_W'(cursor);
			entry.word    = {background, foreground, glyph};
			expected_cells.push_back(entry);
			if (req.char_code != CODE_BACKSPACE)
				cursor = wrap_to_screen(cursor + 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_t got;
		item_t req;
		if (!arst_n) begin
			cursor = 0;
			background = BACKGROUND_RESET;
			foreground = FOREGROUND_RESET;
			expected_cells.delete();
			cells_pending = 0;
		end else begin
			// Results are matched before this edge's request is predicted, since a
			// request cannot produce its cell in the cycle it is taken.
			if (cell_mon.valid && cell_mon.ready) begin
				if (expected_cells.size() == 0) begin
					$error("unexpected cell: cell_address %0d cell_word %h",
						cell_mon.cell_address, cell_mon.cell_word);
					mismatches++;
				end else begin
					got = expected_cells.pop_front();
					if (cell_mon.cell_address !== got.address) begin
						$error("cell_address expected %0d actual %0d",
							got.address, cell_mon.cell_address);
						mismatches++;
					end
					if (cell_mon.cell_word !== got.word) begin
						$error("cell_word expected %h actual %h", got.word, cell_mon.cell_word);
						mismatches++;
					end
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					CFG_BACKGROUND: background = cfg_mon.data;
					CFG_FOREGROUND: foreground = cfg_mon.data;
					default: ;
				endcase
			end
			if (item_mon.valid && item_mon.ready) begin
				req = {item_mon.kind, item_mon.char_code, item_mon.column, item_mon.row};
				predict_cell_write(req);
			end
			cells_pending = expected_cells.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tcw_pkg::*;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 103;
	localparam int HOLD_AFTER     = 150;
	localparam int HOLD_CYCLES    = 300;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   cells_pending;
	int   cycle_count = 0;
	bit   src_calm = 1'b0;

	tcw_item_if item_ch ();
	tcw_cell_if cell_ch ();
	tcw_cfg_if  cfg_ch ();

	text_console_char_writer #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.screen(cell_ch),
		.cfg   (cfg_ch)
	);

	tcw_cell_checker #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_mon     (item_ch),
		.cell_mon     (cell_ch),
		.cfg_mon      (cfg_ch),
		.mismatches   (mismatches),
		.cells_pending(cells_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL text_console_char_writer");
			$finish;
		end
	end

	task automatic send_item(input item_t req);
		int gap;
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.kind      <= req.kind;
		item_ch.char_code <= req.char_code;
		item_ch.column    <= req.column;
		item_ch.row       <= req.row;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [COLOR_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (cells_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic item_t random_request();
		item_t req;
		int    pick;
		req.kind      = 1'($urandom_range(0, 1));
		req.char_code = CHAR_W'($urandom_range(0, 255));
		req.column    = COLUMN_W'($urandom_range(0, 127));
		req.row       = ROW_W'($urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			req.kind = KIND_SETPOS;
			// Most moves stay on screen; the rest exercise the unclipped index.
			if ($urandom_range(0, 3) != 0) begin
				req.column = COLUMN_W'($urandom_range(0, SCREEN_COLUMNS - 1));
				req.row    = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
			end
		end else begin
			req.kind = KIND_CHAR;
			if (pick < 18)
				req.char_code = CODE_NEWLINE;
			else if (pick < 23)
				req.char_code = CODE_TAB;
			else if (pick < 31)
				req.char_code = CODE_BACKSPACE;
		end
		return req;
	endfunction

	initial begin
		int   stall;
		int   taken;
		bit   calm;
		bit   held;
		cell_ch.ready = 1'b0;
		taken = 0;
		calm = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 10);
			if (!held && taken == HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				held = 1'b1;
			end
			if (stall > 0) begin
				cell_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			cell_ch.ready <= 1'b1;
			do @(posedge clk); while (!(cell_ch.valid && cell_ch.ready));
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		int                 ph;
		logic [COLOR_W-1:0] bg;
		logic [COLOR_W-1:0] fg;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.kind      = KIND_CHAR;
		item_ch.char_code = '0;
		item_ch.column    = '0;
		item_ch.row       = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_BACKGROUND;
		cfg_ch.data       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item('{KIND_CHAR, 8'h41, 7'd0, 5'd0});
		send_item('{KIND_CHAR, 8'h00, 7'h7F, 5'h1F});
		send_item('{KIND_CHAR, 8'hFF, 7'd0, 5'd0});
		send_item('{KIND_CHAR, CODE_BACKSPACE, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, 8'hFF, 7'd0, 5'd0});
		// Backspace at the first cell stays there and blanks it.
		send_item('{KIND_CHAR, CODE_BACKSPACE, 7'd0, 5'd0});
		send_item('{KIND_CHAR, CODE_TAB, 7'd0, 5'd0});
		send_item('{KIND_CHAR, CODE_NEWLINE, 7'd0, 5'd0});
		send_item('{KIND_CHAR, 8'h42, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, CODE_NEWLINE, 7'd79, 5'd24});
		send_item('{KIND_CHAR, 8'h5A, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, CODE_TAB, 7'd78, 5'd24});
		send_item('{KIND_CHAR, CODE_TAB, 7'd0, 5'd0});
		send_item('{KIND_CHAR, 8'h7F, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, 8'h00, 7'd127, 5'd31});
		send_item('{KIND_CHAR, CODE_BACKSPACE, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, CODE_BACKSPACE, 7'd127, 5'd0});
		send_item('{KIND_CHAR, 8'h80, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, 8'h00, 7'd0, 5'd31});
		send_item('{KIND_CHAR, 8'h20, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, 8'h00, 7'd80, 5'd3});
		send_item('{KIND_CHAR, 8'h7E, 7'd0, 5'd0});
		send_item('{KIND_SETPOS, 8'h00, 7'd10, 5'd24});
		send_item('{KIND_CHAR, CODE_NEWLINE, 7'd0, 5'd0});
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					bg = 4'd0;
					fg = 4'd0;
				end
				1: begin
					bg = 4'd15;
					fg = 4'd15;
				end
				2: begin
					bg = 4'd15;
					fg = 4'd0;
					write_register(CFG_SPARE_LOW, 4'd15);
					write_register(CFG_SPARE_HIGH, 4'd15);
				end
				default: begin
					bg = COLOR_W'($urandom_range(0, 15));
					fg = COLOR_W'($urandom_range(0, 15));
					if ($urandom_range(0, 1) == 1)
						write_register(CFG_SPARE_LOW, COLOR_W'($urandom_range(0, 15)));
				end
			endcase
			write_register(CFG_BACKGROUND, bg);
			write_register(CFG_FOREGROUND, fg);
			repeat (PHASE_ITEMS) send_item(random_request());
			settle();
		end

		if (mismatches == 0 && cells_pending == 0)
			$display("PASS text_console_char_writer");
		else
			$display("FAIL text_console_char_writer");
		$finish;
	end

endmodule
